@@ rtl/sfsi_pkg.sv @@
package sfsi_pkg;

	// Default store depth
	localparam int NUM_SYMBOLS_DEF = 256;

	// Field widths fixed by the stream format
	localparam int SYM_W   = 8;
	localparam int FREQ_W  = 32;
	localparam int POS_W   = 8;
	localparam int TOTAL_W = 9;
	localparam int CMD_W   = 2;

	// Command codes carried on s_tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_READ   = 2'd2
	} cmd_t;

	// One stored entry
	typedef struct packed {
		logic [SYM_W-1:0]  symbol;
		logic [FREQ_W-1:0] frequency;
	} entry_t;

	// Insert broadcast to every cell
	typedef struct packed {
		logic   en;
		entry_t data;
	} ins_t;

endpackage

@@ rtl/sfsi_cell.sv @@
module sfsi_cell (
	input  logic            clk,
	input  sfsi_pkg::ins_t  ins,       // broadcast insert
	input  logic            occupied,  // cell lies below the entry count
	input  sfsi_pkg::entry_t prev_data, // entry of the lower neighbor
	input  logic            prev_gt,   // lower neighbor moves up on this insert
	output sfsi_pkg::entry_t data,
	output logic            gt
);

	sfsi_pkg::entry_t data_q;

	// An empty cell counts as above every frequency; ties stay below the new entry
	assign gt   = !occupied || (data_q.frequency > ins.data.frequency);
	assign data = data_q;

	// Moving cells take the neighbor's entry, the first moving cell takes the new one
	always_ff @(posedge clk) begin
		if (ins.en && gt) begin
			if (prev_gt) begin
				data_q <= prev_data;
			end else begin
				data_q <= ins.data;
			end
		end
	end

endmodule

@@ rtl/sfsi_read_stage.sv @@
module sfsi_read_stage (
	input  logic             clk,
	input  logic             load,      // this cell is the requested position
	input  logic             shift,     // read chain moves one step down
	input  sfsi_pkg::entry_t own_data,
	input  sfsi_pkg::entry_t next_data, // read register of the upper neighbor
	output sfsi_pkg::entry_t rd_data
);

	sfsi_pkg::entry_t rd_q;

	assign rd_data = rd_q;

	// Capture own entry, then pass entries toward position zero
	always_ff @(posedge clk) begin
		if (load) begin
			rd_q <= own_data;
		end else if (shift) begin
			rd_q <= next_data;
		end
	end

endmodule

@@ rtl/stable_frequency_sorted_insert.sv @@
// Stable ascending frequency list, kept in a row of compare-and-shift cells.
// Input stream s_*: s_tuser carries the command (clear, insert, read), s_tdata
// the symbol, frequency and read position. Every transaction gives exactly one
// result on m_*: symbol and frequency read, entry total, and the flags
// read_valid and dropped.
// On an insert all cells compare the new frequency with their own in parallel
// and the entries above it shift up by one cell; a clear empties the list. The
// result is registered and shows on m_tvalid the cycle after acceptance.
// A read loads the entry at the requested position into a chain of read
// registers that moves it one cell a cycle toward cell zero, where the result
// is taken from; an out-of-range read skips the chain and reports read_valid low.
// One transaction is worked on at a time; s_tready is high while no read walks
// the chain and the output register is empty or being taken in that cycle.
// When the receiver stalls, the result holds in the output register and no new
// transaction is taken. Reset empties the store at once; entry contents are
// not cleared and are only read below the entry total.
module stable_frequency_sorted_insert #(
	parameter int NUM_SYMBOLS = sfsi_pkg::NUM_SYMBOLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // symbol[7:0], frequency[39:8], position[47:40]
	input  logic [1:0]  s_tuser,  // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // out_symbol[7:0], out_frequency[39:8],
	                              // entry_total[48:40], zero fill[55:49]
	output logic [1:0]  m_tuser   // read_valid[0], dropped[1]
);

	localparam int CNT_W      = $clog2(NUM_SYMBOLS + 1);
	localparam int CMP_W      = (CNT_W > sfsi_pkg::TOTAL_W) ? CNT_W : sfsi_pkg::TOTAL_W;
	localparam int READ_CELLS = (NUM_SYMBOLS < 256) ? NUM_SYMBOLS : 256;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} state_t;

	state_t                         state_q;
	logic [CNT_W-1:0]               count_q;
	logic [CNT_W-1:0]               count_next;
	logic [sfsi_pkg::POS_W-1:0]     rd_cnt_q;
	logic                           out_valid_q;
	logic [55:0]                    out_data_q;
	logic [1:0]                     out_user_q;

	sfsi_pkg::cmd_t                 cmd;
	logic [sfsi_pkg::SYM_W-1:0]     in_symbol;
	logic [sfsi_pkg::FREQ_W-1:0]    in_freq;
	logic [sfsi_pkg::POS_W-1:0]     in_pos;
	logic                           accept;
	logic                           full;
	logic                           nonzero;
	logic                           in_range;
	logic                           rd_start;
	logic                           rd_done;
	logic                           drop;
	sfsi_pkg::ins_t                 ins;

	sfsi_pkg::entry_t               cell_data [NUM_SYMBOLS];
	logic                           cell_gt   [NUM_SYMBOLS];
	sfsi_pkg::entry_t               rd_data   [READ_CELLS];

	// Input unpacking
	assign cmd       = sfsi_pkg::cmd_t'(s_tuser);
	assign in_symbol = s_tdata[7:0];
	assign in_freq   = s_tdata[39:8];
	assign in_pos    = s_tdata[47:40];

	assign s_tready = (state_q == ST_IDLE) && (!out_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;

	assign full     = (count_q == CNT_W'(NUM_SYMBOLS));
	assign nonzero  = (in_freq != '0);
	assign in_range = (CMP_W'(in_pos) < CMP_W'(count_q));
	assign drop     = (cmd == sfsi_pkg::CMD_INSERT) && nonzero && full;
	assign rd_start = accept && (cmd == sfsi_pkg::CMD_READ) && in_range;
	assign rd_done  = (state_q == ST_READ) && (rd_cnt_q == '0);

	assign ins.en          = accept && (cmd == sfsi_pkg::CMD_INSERT) && nonzero && !full;
	assign ins.data.symbol    = in_symbol;
	assign ins.data.frequency = in_freq;

	// Entry count after this transaction
	always_comb begin
		count_next = count_q;
		if (accept && (cmd == sfsi_pkg::CMD_CLEAR)) begin
			count_next = '0;
		end else if (ins.en) begin
			count_next = count_q + CNT_W'(1);
		end
	end

	// Cell row
	for (genvar i = 0; i < NUM_SYMBOLS; i++) begin : g_cell
		logic             occ;
		sfsi_pkg::entry_t prev_data;
		logic             prev_gt;

		assign occ = (CNT_W'(i) < count_q);
		if (i == 0) begin : g_first
			assign prev_data = '0;
			assign prev_gt   = 1'b0;
		end else begin : g_rest
			assign prev_data = cell_data[i-1];
			assign prev_gt   = cell_gt[i-1];
		end

		sfsi_cell u_cell (
			.clk       (clk),
			.ins       (ins),
			.occupied  (occ),
			.prev_data (prev_data),
			.prev_gt   (prev_gt),
			.data      (cell_data[i]),
			.gt        (cell_gt[i])
		);
	end

	// Read chain over the readable positions
	for (genvar i = 0; i < READ_CELLS; i++) begin : g_read
		sfsi_pkg::entry_t next_data;

		if (i == READ_CELLS - 1) begin : g_top
			assign next_data = '0;
		end else begin : g_mid
			assign next_data = rd_data[i+1];
		end

		sfsi_read_stage u_read (
			.clk       (clk),
			.load      (rd_start && (in_pos == sfsi_pkg::POS_W'(i))),
			.shift     (state_q == ST_READ),
			.own_data  (cell_data[i]),
			.next_data (next_data),
			.rd_data   (rd_data[i])
		);
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rd_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			unique case (state_q)
				ST_IDLE: begin
					if (rd_start) begin
						state_q  <= ST_READ;
						rd_cnt_q <= in_pos;
					end
				end
				ST_READ: begin
					if (rd_cnt_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						rd_cnt_q <= rd_cnt_q - sfsi_pkg::POS_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if ((accept && !rd_start) || rd_done) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (rd_done) begin
			out_data_q <= {7'd0, sfsi_pkg::TOTAL_W'(count_q),
			               rd_data[0].frequency, rd_data[0].symbol};
			out_user_q <= 2'b01;
		end else if (accept && !rd_start) begin
			out_data_q <= {7'd0, sfsi_pkg::TOTAL_W'(count_next), 40'd0};
			out_user_q <= {drop, 1'b0};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

@@ bench/stable_frequency_sorted_insert_tb.sv @@
module stable_frequency_sorted_insert_tb;
	import sfsi_pkg::*;

	localparam int DEPTH        = NUM_SYMBOLS_DEF;
	localparam int TARGET_ITEMS = 1600;
	localparam int HOLD_CYCLES  = 400;
	// longest read walks the whole chain
	localparam int TAIL_CYCLES  = DEPTH + 40;
	localparam int CYCLE_LIMIT  = 2000000;
	localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [SYM_W-1:0]  symbol;
		logic [FREQ_W-1:0] frequency;
		logic [POS_W-1:0]  position;
	} order_t;

	typedef struct packed {
		logic [SYM_W-1:0]   symbol;
		logic [FREQ_W-1:0]  frequency;
		logic [TOTAL_W-1:0] total;
		logic               rd_valid;
		logic               dropped;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // symbol[7:0], frequency[39:8], position[47:40]
	logic [1:0]  s_tuser;   // command[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // out_symbol[7:0], out_frequency[39:8], entry_total[48:40]
	logic [1:0]  m_tuser;   // read_valid[0], dropped[1]

	stable_frequency_sorted_insert i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Sorted list kept by the predictor
	logic [SYM_W-1:0]  list_sym  [DEPTH];
	logic [FREQ_W-1:0] list_freq [DEPTH];
	int                list_len;

	order_t pending_orders [$];
	reply_t due_replies [$];

	order_t next_order;
	order_t seen_order;
	reply_t want;

	int  gen_len;
	int  n_items;
	int  items_taken;
	int  items_sent;
	int  insert_count;
	int  drop_count;
	int  hit_count;
	int  peak_total;
	int  fail_count;
	int  cycle_count;
	int  phase;
	int  send_gap_pct;
	int  recv_stall_pct;
	int  hold_left;
	bit  pressure_done;

	always #10 clk = ~clk;

	// Apply one transaction to the sorted list and return its result
	function automatic reply_t apply_order(order_t o);
		reply_t r;
		int     slot;
		int     k;
		r = '0;
		case (o.command)
			CMD_CLEAR: begin
				list_len = 0;
			end
			CMD_INSERT: begin
				if (o.frequency != 0) begin
					if (list_len >= DEPTH) begin
						r.dropped = 1'b1;
					end else begin
						// equal counts stay ahead of the newcomer
						slot = 0;
						while (slot < list_len && list_freq[slot] <= o.frequency)
							slot++;
						for (k = list_len; k > slot; k--) begin
							list_sym[k]  = list_sym[k-1];
							list_freq[k] = list_freq[k-1];
						end
						list_sym[slot]  = o.symbol;
						list_freq[slot] = o.frequency;
						list_len++;
					end
				end
			end
			CMD_READ: begin
				if (o.position < list_len) begin
					r.rd_valid  = 1'b1;
					r.symbol    = list_sym[o.position];
					r.frequency = list_freq[o.position];
				end
			end
			default: begin
			end
		endcase
		r.total = TOTAL_W'(list_len);
		return r;
	endfunction

	function automatic logic [FREQ_W-1:0] pick_frequency();
		int r;
		r = int'($urandom_range(99));
		if (r < 5)
			return '0;
		if (r < 55)
			return FREQ_W'($urandom_range(1, 16));
		if (r < 70)
			return {FREQ_W{1'b1}} - FREQ_W'($urandom_range(0, 3));
		return FREQ_W'($urandom());
	endfunction

	// Mostly positions inside the list, some beyond it
	function automatic logic [POS_W-1:0] pick_position();
		if (gen_len > 0 && $urandom_range(99) < 80)
			return POS_W'($urandom_range(0, gen_len - 1));
		return POS_W'($urandom_range(0, DEPTH - 1));
	endfunction

	function automatic void add_order(logic [CMD_W-1:0] command, logic [SYM_W-1:0] symbol,
		logic [FREQ_W-1:0] frequency, logic [POS_W-1:0] position);
		order_t o;
		o.command   = command;
		o.symbol    = symbol;
		o.frequency = frequency;
		o.position  = position;
		pending_orders.push_back(o);
		if (command == CMD_CLEAR)
			gen_len = 0;
		else if (command == CMD_INSERT && frequency != 0 && gen_len < DEPTH)
			gen_len++;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, got_val);
			fail_count++;
		end
	endfunction

	// Driver: new transaction offered at the falling edge once the last one is taken
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || items_taken == items_sent)) begin
			if (pending_orders.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
				next_order = pending_orders.pop_front();
				items_sent++;
				s_tvalid <= 1'b1;
				s_tdata  <= {next_order.position, next_order.frequency, next_order.symbol};
				s_tuser  <= next_order.command;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls plus one long hold-off while the sender keeps going
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (arst_n && !pressure_done && items_taken >= n_items / 8) begin
			pressure_done = 1'b1;
			hold_left = HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Input monitor: predict the result of each accepted transaction
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			seen_order.command   = s_tuser;
			seen_order.symbol    = s_tdata[7:0];
			seen_order.frequency = s_tdata[39:8];
			seen_order.position  = s_tdata[47:40];
			due_replies.push_back(apply_order(seen_order));
			if (seen_order.command == CMD_INSERT)
				insert_count++;
			items_taken++;
			phase = (items_taken * 4) / n_items;
			case (phase)
				1: begin
					send_gap_pct = 63;
					recv_stall_pct = 0;
				end
				2: begin
					send_gap_pct = 0;
					recv_stall_pct = 63;
				end
				3, 4: begin
					send_gap_pct = 23;
					recv_stall_pct = 23;
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
		end
	end

	// Output monitor: compare each result with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (due_replies.size() == 0) begin
				$error("result transaction with no prediction waiting");
				fail_count++;
			end else begin
				want = due_replies.pop_front();
				check_field("out_symbol", 32'(want.symbol), 32'(m_tdata[7:0]));
				check_field("out_frequency", want.frequency, m_tdata[39:8]);
				check_field("entry_total", 32'(want.total), 32'(m_tdata[48:40]));
				check_field("read_valid", 32'(want.rd_valid), 32'(m_tuser[0]));
				check_field("dropped", 32'(want.dropped), 32'(m_tuser[1]));
			end
			if (m_tuser[1])
				drop_count++;
			if (m_tuser[0])
				hit_count++;
			if (int'(m_tdata[48:40]) > peak_total)
				peak_total = int'(m_tdata[48:40]);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d of %0d transactions taken",
				cycle_count, items_taken, n_items);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int burst;
		int ins_pct;
		int i;
		int p;

		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		list_len = 0;
		gen_len = 0;
		items_taken = 0;
		items_sent = 0;
		insert_count = 0;
		drop_count = 0;
		hit_count = 0;
		peak_total = 0;
		fail_count = 0;
		cycle_count = 0;
		phase = 0;
		send_gap_pct = 0;
		recv_stall_pct = 0;
		hold_left = 0;
		pressure_done = 1'b0;

		// Directed: empty read, zero count, extremes, ties, reads past the end,
		// spare command, clear
		add_order(CMD_READ, 8'h00, 32'h0, 8'h00);
		add_order(CMD_INSERT, 8'hFF, 32'h0, 8'hFF);
		add_order(CMD_INSERT, 8'h00, 32'hFFFF_FFFF, 8'h00);
		add_order(CMD_INSERT, 8'hFF, 32'h1, 8'h00);
		add_order(CMD_INSERT, 8'hA5, 32'h1, 8'hFF);
		add_order(CMD_INSERT, 8'h5A, 32'h8000_0000, 8'h00);
		add_order(CMD_INSERT, 8'h3C, 32'hFFFF_FFFF, 8'h00);
		for (p = 0; p <= 5; p++)
			add_order(CMD_READ, 8'hFF, 32'hFFFF_FFFF, POS_W'(p));
		add_order(CMD_READ, 8'h00, 32'h0, 8'hFF);
		add_order(CMD_SPARE, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
		add_order(CMD_SPARE, 8'h00, 32'h0, 8'h00);
		add_order(CMD_CLEAR, 8'hFF, 32'hFFFF_FFFF, 8'hFF);
		add_order(CMD_READ, 8'h00, 32'h0, 8'h00);
		add_order(CMD_CLEAR, 8'h00, 32'h0, 8'h00);

		// Fill the list past full, then read both ends of it
		for (i = 0; i < DEPTH + 4; i++)
			add_order(CMD_INSERT, SYM_W'($urandom), FREQ_W'($urandom_range(1, 64)),
				POS_W'($urandom));
		add_order(CMD_INSERT, SYM_W'($urandom), 32'h0, POS_W'($urandom));
		add_order(CMD_INSERT, SYM_W'($urandom), 32'hFFFF_FFFF, POS_W'($urandom));
		add_order(CMD_READ, SYM_W'($urandom), FREQ_W'($urandom), 8'hFF);
		add_order(CMD_READ, SYM_W'($urandom), FREQ_W'($urandom), 8'h00);
		add_order(CMD_READ, SYM_W'($urandom), FREQ_W'($urandom), pick_position());
		add_order(CMD_SPARE, SYM_W'($urandom), FREQ_W'($urandom), POS_W'($urandom));

		// Random: mostly clear / insert / read runs, some noise
		while (pending_orders.size() < TARGET_ITEMS) begin
			if ($urandom_range(99) < 85) begin
				if ($urandom_range(99) < 70)
					add_order(CMD_CLEAR, SYM_W'($urandom), FREQ_W'($urandom),
						POS_W'($urandom));
				if ($urandom_range(99) < 4) begin
					burst = DEPTH + 40;
					ins_pct = 97;
				end else begin
					burst = int'($urandom_range(1, 40));
					ins_pct = 75;
				end
				for (i = 0; i < burst; i++) begin
					if ($urandom_range(99) < ins_pct)
						add_order(CMD_INSERT, SYM_W'($urandom), pick_frequency(),
							POS_W'($urandom));
					else
						add_order(CMD_READ, SYM_W'($urandom), FREQ_W'($urandom),
							pick_position());
				end
				repeat ($urandom_range(1, 8))
					add_order(CMD_READ, SYM_W'($urandom), FREQ_W'($urandom),
						pick_position());
			end else begin
				repeat ($urandom_range(1, 6))
					add_order(CMD_W'($urandom_range(0, 3)), SYM_W'($urandom),
						pick_frequency(), POS_W'($urandom));
			end
		end
		n_items = pending_orders.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (!(items_taken == n_items && due_replies.size() == 0))
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d transactions in %0d cycles: %0d inserts, %0d refused on a full list,",
			n_items, cycle_count, insert_count, drop_count);
		$display("%0d reads inside the list, largest list held %0d entries.",
			hit_count, peak_total);
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", fail_count);
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/sfsi_pkg.sv
rtl/sfsi_cell.sv
rtl/sfsi_read_stage.sv
rtl/stable_frequency_sorted_insert.sv
bench/stable_frequency_sorted_insert_tb.sv
